// ===== design/mhpq_pkg.sv =====
// package for the max-heap priority queue: sizes, codes, payload types and helpers
`timescale 1ns / 1ps
package mhpq_pkg;

	// heap size and derived widths
	localparam int CAPACITY = 128;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CW       = $clog2(CAPACITY + 1);
	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 8;

	// request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] pos_t;

	typedef struct packed {
		logic  req_type;
		word_t value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               top_valid;
		word_t              top_value;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	// one write port and two read ports of the heap store
	typedef struct packed {
		logic  we;
		addr_t waddr;
		word_t wdata;
		addr_t raddr_a;
		addr_t raddr_b;
	} mem_req_t;

	// one-based heap position to zero-based store address
	function automatic addr_t pos_addr(input logic [CW:0] p);
		logic [CW:0] t;
		t = p - 1'b1;
		return t[AW-1:0];
	endfunction

endpackage

// ===== design/mhpq_ram.sv =====
// heap store: one write port, two registered read ports
`timescale 1ns / 1ps
module mhpq_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports, registered
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== design/mhpq_ctrl.sv =====
// sift sequencer: walks the heap in the store with a moving hole
`timescale 1ns / 1ps
module mhpq_ctrl import mhpq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  req_t     req_data,
	output mem_req_t mem,
	input  word_t    rd_a,
	input  word_t    rd_b,
	input  logic     res_slot_free,
	output logic     res_load,
	output rsp_t     res_data
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_UP_RD  = 3'd1;
	localparam logic [2:0] S_UP_CMP = 3'd2;
	localparam logic [2:0] S_LAST   = 3'd3;
	localparam logic [2:0] S_DN_RD  = 3'd4;
	localparam logic [2:0] S_DN_CMP = 3'd5;
	localparam logic [2:0] S_RESULT = 3'd6;

	logic [2:0] state_q, state_d;
	pos_t       count_q, count_d;
	pos_t       pos_q, pos_d;
	word_t      val_q, val_d;
	word_t      top_q, top_d;
	logic [1:0] status_q, status_d;
	logic       rc_ok_q, rc_ok_d;

	logic        accept;
	logic [CW:0] lc_pos, rc_pos, pick_pos, count_x, pos_x;
	pos_t        parent_pos;
	logic        pick_right;
	word_t       pick_val;
	logic        wr_root;

	assign accept     = req_valid && !req_stall;
	assign req_stall  = (state_q != S_IDLE);
	assign pos_x      = {1'b0, pos_q};
	assign count_x    = {1'b0, count_q};
	assign lc_pos     = {pos_q, 1'b0};
	assign rc_pos     = {pos_q, 1'b1};
	assign parent_pos = pos_q >> 1;
	assign pick_right = rc_ok_q && (rd_b > rd_a);
	assign pick_val   = pick_right ? rd_b : rd_a;
	assign pick_pos   = pick_right ? rc_pos : lc_pos;
	assign wr_root    = (pos_q == CW'(1));

	// next-state and store access
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		pos_d       = pos_q;
		val_d       = val_q;
		status_d    = status_q;
		rc_ok_d     = rc_ok_q;
		mem.we      = 1'b0;
		mem.waddr   = pos_addr(pos_x);
		mem.wdata   = val_q;
		mem.raddr_a = pos_addr(pos_x);
		mem.raddr_b = pos_addr(pos_x);
		res_load    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_d = ST_OK;
					if (req_data.req_type == REQ_INSERT) begin
						if (count_x >= (CW+1)'(CAPACITY)) begin
							status_d = ST_FULL;
							state_d  = S_RESULT;
						end else begin
							count_d = count_q + 1'b1;
							pos_d   = count_q + 1'b1;
							val_d   = req_data.value;
							state_d = S_UP_RD;
						end
					end else begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_RESULT;
						end else begin
							mem.raddr_a = pos_addr(count_x);
							count_d     = count_q - 1'b1;
							state_d     = S_LAST;
						end
					end
				end
			end
			S_UP_RD: begin
				if (wr_root) begin
					mem.we  = 1'b1;
					state_d = S_RESULT;
				end else begin
					mem.raddr_a = pos_addr({1'b0, parent_pos});
					state_d     = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				mem.we = 1'b1;
				if (val_q > rd_a) begin
					mem.wdata = rd_a;
					pos_d     = parent_pos;
					state_d   = S_UP_RD;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_LAST: begin
				val_d   = rd_a;
				pos_d   = CW'(1);
				state_d = S_DN_RD;
			end
			S_DN_RD: begin
				if (lc_pos > count_x) begin
					mem.we  = (count_q != '0);
					state_d = S_RESULT;
				end else begin
					mem.raddr_a = pos_addr(lc_pos);
					mem.raddr_b = pos_addr(rc_pos);
					rc_ok_d     = (rc_pos <= count_x);
					state_d     = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				mem.we = 1'b1;
				if (pick_val > val_q) begin
					mem.wdata = pick_val;
					pos_d     = pick_pos[CW-1:0];
					state_d   = S_DN_RD;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (res_slot_free) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// root mirror, kept so the result never needs a store read
	always_comb begin
		top_d = top_q;
		if (mem.we && wr_root) begin
			top_d = mem.wdata;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		val_q    <= val_d;
		top_q    <= top_d;
		status_q <= status_d;
		rc_ok_q  <= rc_ok_d;
	end

	// result fields
	always_comb begin
		res_data.status      = status_q;
		res_data.top_valid   = (count_q != '0);
		res_data.top_value   = (count_q != '0) ? top_q : '0;
		res_data.entry_count = COUNT_W'(count_q);
	end

endmodule

// ===== design/max_heap_priority_queue.sv =====
// top level of the max-heap priority queue: store, sequencer and result register
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/req_stall | req_data (req_type, value)
//  rsp     | out | rsp_valid/rsp_stall | rsp_data (status, top_valid, top_value, entry_count)
//
// one request at a time; a full insert or empty remove goes straight to the result state
// insert: a parent read then a compare/write per level climbed; it ends with a root write or a compare that stops it
// remove: reads the last entry, then a child read and a compare/write per level descended
// each level is a store read then a store compare/write, which sets the rate;
// the queue returns to idle as the result is registered, then takes the next request
// reset empties the heap at once; store contents are never cleared
// the next request is taken while a result waits under rsp_stall
`timescale 1ns / 1ps
module max_heap_priority_queue import mhpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	mem_req_t mem;
	word_t    rd_a, rd_b;
	logic     res_load, res_slot_free;
	rsp_t     res_data;
	logic     rsp_valid_q;
	rsp_t     rsp_q;

	mhpq_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(WORD_W)
	) u_ram (
		.clk    (clk),
		.we     (mem.we),
		.waddr  (mem.waddr),
		.wdata  (mem.wdata),
		.raddr_a(mem.raddr_a),
		.raddr_b(mem.raddr_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	mhpq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_data     (req_data),
		.mem          (mem),
		.rd_a         (rd_a),
		.rd_b         (rd_b),
		.res_slot_free(res_slot_free),
		.res_load     (res_load),
		.res_data     (res_data)
	);

	// result register
	assign res_slot_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ===== design/mhpq_chk.sv =====
// port checker for the max-heap priority queue, bound to the top level
`timescale 1ns / 1ps
module mhpq_chk import mhpq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp_data
);

	// a waiting result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// one request in flight: the queue is busy the cycle after a request
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in work");

	// an empty heap shows no top and no entries
	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == ST_EMPTY) |->
		!rsp_data.top_valid && (rsp_data.top_value == '0) && (rsp_data.entry_count == '0))
		else $error("empty remove shows a top");

	// no top means zero value
	a_no_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.top_valid |-> (rsp_data.top_value == '0))
		else $error("top value without a top");

	// a full insert reports a full heap
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == ST_FULL) |->
		rsp_data.top_valid && (rsp_data.entry_count == COUNT_W'(CAPACITY)))
		else $error("full insert with a heap that is not full");

endmodule

bind max_heap_priority_queue mhpq_chk u_chk (.*);

// ===== test/max_heap_priority_queue_tb.sv =====
// testbench for the max-heap priority queue: directed and random requests checked against a heap predictor
`timescale 1ns / 1ps
module max_heap_priority_queue_tb;
	import mhpq_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	// predicted heap contents, one-based like the block
	word_t heap_model [1:CAPACITY];
	int heap_size = 0;
	rsp_t expected_rsps [$];
	int mismatch_count = 0;
	int burst_left = 0;
	int stall_pct = 0;
	int stall_left = 0;

	max_heap_priority_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// applies one request to the predicted heap and returns the result it should give
	function automatic rsp_t predict_heap_step(input req_t r);
		rsp_t res;
		int pos;
		int nxt;
		word_t tmp;
		logic settled;
		res = '0;
		res.status = ST_OK;
		if (r.req_type == REQ_INSERT) begin
			if (heap_size >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				heap_size++;
				heap_model[heap_size] = r.value;
				pos = heap_size;
				// climb while the parent is strictly smaller
				while (pos > 1 && heap_model[pos] > heap_model[pos / 2]) begin
					tmp = heap_model[pos];
					heap_model[pos] = heap_model[pos / 2];
					heap_model[pos / 2] = tmp;
					pos = pos / 2;
				end
			end
		end else if (heap_size == 0) begin
			res.status = ST_EMPTY;
		end else begin
			heap_model[1] = heap_model[heap_size];
			heap_size--;
			pos = 1;
			settled = 1'b0;
			// descend toward the larger child, left wins ties
			while (!settled && 2 * pos <= heap_size) begin
				nxt = 2 * pos;
				if (nxt + 1 <= heap_size && heap_model[nxt + 1] > heap_model[nxt])
					nxt = nxt + 1;
				if (heap_model[nxt] > heap_model[pos]) begin
					tmp = heap_model[pos];
					heap_model[pos] = heap_model[nxt];
					heap_model[nxt] = tmp;
					pos = nxt;
				end else begin
					settled = 1'b1;
				end
			end
		end
		res.top_valid = (heap_size > 0);
		res.top_value = (heap_size > 0) ? heap_model[1] : '0;
		res.entry_count = COUNT_W'(heap_size);
		return res;
	endfunction

	// mix of full-range, clustered and extreme values
	function automatic word_t random_value();
		word_t v;
		case ($urandom_range(0, 3))
			0: v = word_t'(int'($urandom_range(0, 7)) - 4);
			1: v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: v = word_t'($urandom());
		endcase
		return v;
	endfunction

	// drives one request in bursts with random gaps, records its expected result once taken
	task automatic send_request(input logic kind, input word_t value);
		int gap;
		req_t r;
		r.req_type = kind;
		r.value = value;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			case ($urandom_range(0, 3))
				1: gap = $urandom_range(1, 3);
				2: gap = $urandom_range(4, 24);
				default: gap = 0;
			endcase
			if (gap > 0) begin
				req_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_valid = 1'b1;
		req_data = r;
		do @(posedge clk); while (req_stall);
		expected_rsps.push_back(predict_heap_step(r));
	endtask

	// receiver stall: probability is redrawn whenever its random hold count runs out, including no stall at all
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(50, 300);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 90;
			endcase
		end
		stall_left--;
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result: status %0d top_valid %0d top_value %0d count %0d",
					$time, rsp_data.status, rsp_data.top_valid, rsp_data.top_value,
					rsp_data.entry_count);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp_data !== want) begin
					mismatch_count++;
					$display("%0t: expected status %0d top_valid %0d top_value %0d count %0d",
						$time, want.status, want.top_valid, want.top_value, want.entry_count);
					$display("%0t: actual   status %0d top_valid %0d top_value %0d count %0d",
						$time, rsp_data.status, rsp_data.top_valid, rsp_data.top_value,
						rsp_data.entry_count);
				end
			end
		end
	end

	// removes on an empty heap
	task automatic test_remove_empty();
		send_request(REQ_REMOVE, 32'sh7fffffff);
		send_request(REQ_REMOVE, 32'sh80000000);
	endtask

	// largest, smallest and sign-boundary values, drained past empty
	task automatic test_value_extremes();
		send_request(REQ_INSERT, 32'sh00000000);
		send_request(REQ_INSERT, 32'sh7fffffff);
		send_request(REQ_INSERT, 32'sh80000000);
		send_request(REQ_INSERT, -32'sd1);
		send_request(REQ_INSERT, 32'sd1);
		send_request(REQ_INSERT, 32'sh80000001);
		repeat (7) send_request(REQ_REMOVE, word_t'($urandom()));
	endtask

	// equal keys: no swap on ties, equal children pick the left
	task automatic test_equal_keys();
		repeat (5) send_request(REQ_INSERT, 32'sd5);
		send_request(REQ_INSERT, 32'sd7);
		repeat (3) send_request(REQ_REMOVE, 32'sd0);
	endtask

	// fill to capacity, push against the full heap, then drain
	task automatic test_full_heap();
		while (heap_size < CAPACITY)
			send_request(REQ_INSERT, random_value());
		send_request(REQ_INSERT, 32'sh7fffffff);
		send_request(REQ_INSERT, 32'sh80000000);
		send_request(REQ_INSERT, random_value());
		while (heap_size > 0)
			send_request(REQ_REMOVE, random_value());
		send_request(REQ_REMOVE, random_value());
	endtask

	// random traffic with insert ratios that sweep the fill level up and down
	task automatic test_random_traffic();
		int insert_pct [4] = '{75, 25, 60, 40};
		foreach (insert_pct[p]) begin
			repeat (360) begin
				if ($urandom_range(0, 99) < insert_pct[p])
					send_request(REQ_INSERT, random_value());
				else
					send_request(REQ_REMOVE, random_value());
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_remove_empty();
		test_value_extremes();
		test_equal_keys();
		test_full_heap();
		test_random_traffic();

		@(negedge clk);
		req_valid = 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule
